@@ design/ssq_pkg.sv @@
// Package for the stable sorted priority queue.
// Holds sizes, the request and result item types, and the control structs.
// No dependencies.
package ssq_pkg;

	localparam int QUEUE_DEPTH   = 32;
	localparam int PRIORITY_BITS = 8;
	localparam int TAG_BITS      = 16;
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

	// Operation codes of a request item.
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic                     cmd;
		logic [PRIORITY_BITS-1:0] task_priority;
		logic [TAG_BITS-1:0]      task_tag;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [PRIORITY_BITS-1:0] out_priority;
		logic [TAG_BITS-1:0]      out_tag;
		logic [CNT_W-1:0]         entry_count;
		logic                     head_valid;
		logic [PRIORITY_BITS-1:0] head_priority;
		logic [TAG_BITS-1:0]      head_tag;
	} rsp_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load;
		logic    enq;
		logic    deq;
		status_t code;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

	typedef enum logic {
		CS_IDLE,
		CS_HOLD
	} ctrl_state_t;

endpackage

@@ design/ssq_ctrl.sv @@
// Controller of the stable sorted priority queue.
// Handles both handshakes and issues commands to the datapath; uses ssq_pkg.
module ssq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_cmd,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  ssq_pkg::dp_stat_t stat,
	output ssq_pkg::dp_cmd_t  cmd
);

	ssq_pkg::ctrl_state_t state_q, state_d;
	logic accept;

	// A new item enters unless a held result is stalled.
	assign req_stall = (state_q == ssq_pkg::CS_HOLD) && rsp_stall;
	assign accept    = req_valid && !req_stall;

	// Next state: a result is held from acceptance until it is taken.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ssq_pkg::CS_IDLE: begin
				if (accept) state_d = ssq_pkg::CS_HOLD;
			end
			ssq_pkg::CS_HOLD: begin
				if (accept) state_d = ssq_pkg::CS_HOLD;
				else if (!rsp_stall) state_d = ssq_pkg::CS_IDLE;
			end
			default: state_d = ssq_pkg::CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ssq_pkg::CS_IDLE;
		else state_q <= state_d;
	end

	// Outputs: decide the operation and its status code.
	always_comb begin
		cmd.load = accept;
		cmd.enq  = 1'b0;
		cmd.deq  = 1'b0;
		cmd.code = ssq_pkg::ST_DONE;
		if (req_cmd == ssq_pkg::CMD_DEQ) begin
			if (stat.empty) cmd.code = ssq_pkg::ST_EMPTY;
			else cmd.deq = accept;
		end else begin
			if (stat.full) cmd.code = ssq_pkg::ST_FULL;
			else cmd.enq = accept;
		end
		rsp_valid = (state_q == ssq_pkg::CS_HOLD);
	end

endmodule

@@ design/ssq_datapath.sv @@
// Datapath of the stable sorted priority queue: a shift-register sorted list
// with parallel compare per slot, entry counter and result register. Uses ssq_pkg.
module ssq_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  ssq_pkg::req_t     req,
	input  ssq_pkg::dp_cmd_t  cmd,
	output ssq_pkg::dp_stat_t stat,
	output ssq_pkg::rsp_t     rsp
);

	localparam int D  = ssq_pkg::QUEUE_DEPTH;
	localparam int PW = ssq_pkg::PRIORITY_BITS;
	localparam int TW = ssq_pkg::TAG_BITS;
	localparam int CW = ssq_pkg::CNT_W;

	logic [PW-1:0] prio_q [D];
	logic [TW-1:0] tag_q  [D];
	logic [PW-1:0] prio_d [D];
	logic [TW-1:0] tag_d  [D];
	logic [D-1:0]  ge;
	logic [CW-1:0] count_q, count_d;
	ssq_pkg::rsp_t rsp_q;

	assign stat.full  = (count_q == CW'(D));
	assign stat.empty = (count_q == '0);

	// Each stored slot compares its priority with the new one.
	always_comb begin
		for (int k = 0; k < D; k++) begin
			ge[k] = (CW'(k) < count_q) && (prio_q[k] >= req.task_priority);
		end
	end

	// Slot update: hold, take the new entry, shift down on insert, shift up on removal.
	for (genvar k = 0; k < D; k++) begin : g_slot
		logic          ge_prev;
		logic [PW-1:0] prio_prev, prio_next;
		logic [TW-1:0] tag_prev, tag_next;

		if (k == 0) begin : g_first
			assign ge_prev   = 1'b0;
			assign prio_prev = req.task_priority;
			assign tag_prev  = req.task_tag;
		end else begin : g_rest
			assign ge_prev   = ge[k-1];
			assign prio_prev = prio_q[k-1];
			assign tag_prev  = tag_q[k-1];
		end

		if (k == D - 1) begin : g_last
			assign prio_next = prio_q[k];
			assign tag_next  = tag_q[k];
		end else begin : g_inner
			assign prio_next = prio_q[k+1];
			assign tag_next  = tag_q[k+1];
		end

		always_comb begin
			prio_d[k] = prio_q[k];
			tag_d[k]  = tag_q[k];
			if (cmd.enq && !ge[k]) begin
				if (ge_prev || (k == 0)) begin
					prio_d[k] = req.task_priority;
					tag_d[k]  = req.task_tag;
				end else begin
					prio_d[k] = prio_prev;
					tag_d[k]  = tag_prev;
				end
			end else if (cmd.deq) begin
				prio_d[k] = prio_next;
				tag_d[k]  = tag_next;
			end
		end

		always_ff @(posedge clk) begin
			prio_q[k] <= prio_d[k];
			tag_q[k]  <= tag_d[k];
		end
	end

	// Entry counter.
	always_comb begin
		count_d = count_q;
		if (cmd.enq) count_d = count_q + 1'b1;
		else if (cmd.deq) count_d = count_q - 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else count_q <= count_d;
	end

	// Result register, loaded with the state after the step.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rsp_q.status        <= cmd.code;
			rsp_q.out_priority  <= cmd.deq ? prio_q[0] : '0;
			rsp_q.out_tag       <= cmd.deq ? tag_q[0] : '0;
			rsp_q.entry_count   <= count_d;
			rsp_q.head_valid    <= (count_d != '0);
			rsp_q.head_priority <= (count_d != '0) ? prio_d[0] : '0;
			rsp_q.head_tag      <= (count_d != '0) ? tag_d[0] : '0;
		end
	end

	assign rsp = rsp_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(D))
		else $error("entry count exceeds queue depth");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("enqueue did not raise the entry count");

	a_deq_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |=> count_q == CW'($past(count_q) - 1'b1))
		else $error("dequeue did not lower the entry count");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= CW'(2) |-> prio_q[0] >= prio_q[1])
		else $error("head priority below its successor");

endmodule

@@ design/stable_sorted_priority_queue.sv @@
// Stable sorted priority queue: one request item in, one result item out.
// A result is valid the cycle after its request is accepted.
// Throughput: one item per cycle; all slots compare and shift in parallel.
// A stalled result holds off the next request until it is taken.
// Reset clears the entry count and the handshake state; slot contents stay.
module stable_sorted_priority_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  ssq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output ssq_pkg::rsp_t rsp
);

	ssq_pkg::dp_cmd_t  cmd;
	ssq_pkg::dp_stat_t stat;

	ssq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ssq_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule
